### design/r2fft_pkg.sv
// Shared types, constants and functions of the radix-2 FFT block.
`timescale 1ns / 1ps
package r2fft_pkg;

    localparam int LOG2_POINTS = 11;
    localparam int POINTS      = 1 << LOG2_POINTS;
    localparam int HALF_PTS    = POINTS / 2;
    localparam int QUARTER     = POINTS / 4;
    localparam int SAMPLE_W    = 16;
    localparam int TW_W        = 18;
    localparam int DATA_W      = 28;
    localparam int ADDR_W      = LOG2_POINTS + 1;
    localparam int CNT_W       = LOG2_POINTS;
    localparam int BF_W        = LOG2_POINTS - 1;
    localparam int STAGE_W     = 4;
    localparam int TWI_W       = BF_W;
    localparam int PROD_W      = DATA_W + TW_W;
    localparam int TR_W        = DATA_W + 2;
    localparam int SUM_W       = DATA_W + 3;

    localparam logic [63:0] PI_Q32  = 64'd13493037705;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef logic [TW_W-1:0] t_tw_rom [0:QUARTER];

    // Controller to datapath commands
    typedef struct packed {
        logic              load_we;
        logic              out_rd;
        logic [CNT_W-1:0]  out_index;
        logic              xf_rd;
        logic              mul_en;
        logic              neg_im;
        logic              sum_en;
        logic              add_en;
        logic              wr_b;
        logic              wr_a;
        logic              out_inv;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic [TWI_W-1:0]  tw_idx;
        logic              tw_upper;
    } t_cmd;

    function automatic logic [CNT_W-1:0] bit_rev(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        for (int i = 0; i < CNT_W; i++) r[CNT_W-1-i] = v[i];
        return r;
    endfunction

    // Saturate a grown sum to the data width
    function automatic logic [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi) return hi[DATA_W-1:0];
        if (v < lo) return lo[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

    // Quarter-wave twiddle table, Q30 Taylor series evaluated at elaboration
    function automatic t_tw_rom build_rom(input logic want_sin);
        t_tw_rom     rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] q;
        logic [63:0] r;
        longint      sn;
        longint      cs;
        int          sh;
        sh = 31 - TW_W;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (PI_Q32 * 64'(k) + (64'd1 << LOG2_POINTS)) >> (LOG2_POINTS + 1);
            x2 = (x * x) >> 30;
            ts = x;
            tc = ONE_Q30;
            sn = longint'(x);
            cs = longint'(ONE_Q30);
            for (int n = 1; n <= 16; n++) begin
                ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    sn = sn - longint'(ts);
                    cs = cs - longint'(tc);
                end else begin
                    sn = sn + longint'(ts);
                    cs = cs + longint'(tc);
                end
            end
            if (want_sin) q = (sn < 0) ? 64'd0 : 64'(sn);
            else          q = (cs < 0) ? 64'd0 : 64'(cs);
            if (q > ONE_Q30) q = ONE_Q30;
            r = (q + (64'd1 << (sh - 1))) >> sh;
            if (r > ((64'd1 << (TW_W - 1)) - 64'd1)) r = (64'd1 << (TW_W - 1)) - 64'd1;
            rom[k] = r[TW_W-1:0];
        end
        return rom;
    endfunction

    localparam t_tw_rom COS_ROM = build_rom(1'b0);
    localparam t_tw_rom SIN_ROM = build_rom(1'b1);

endpackage

### design/r2fft_ctrl.sv
// Controller: load sequencing, bank swap and butterfly scheduling.
`timescale 1ns / 1ps
module r2fft_ctrl
    import r2fft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_RD   = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_ADD  = 7'b0010000,
        S_WB   = 7'b0100000,
        S_WA   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_load_cnt, n_load_cnt;
    logic               r_bank, n_bank;
    logic               r_ready, n_ready;
    logic               r_inv;
    logic               r_xf_inv, n_xf_inv;
    logic               r_out_inv, n_out_inv;
    logic               r_xf_bank, n_xf_bank;
    logic [STAGE_W-1:0] r_lh, n_lh;
    logic [BF_W-1:0]    r_m, n_m;

    logic               accept;
    logic [BF_W-1:0]    bf_mask;
    logic [CNT_W-1:0]   addr_a;
    logic [CNT_W-1:0]   addr_b;
    logic [BF_W-1:0]    tw_k;

    assign busy   = (r_state != S_LOAD);
    assign accept = start && (r_state == S_LOAD);

    // Butterfly addresses: insert a zero bit at the stage position
    always_comb begin
        bf_mask = BF_W'((CNT_W'(1) << r_lh) - CNT_W'(1));
        addr_a  = ((CNT_W'(r_m) >> r_lh) << (r_lh + STAGE_W'(1))) | CNT_W'(r_m & bf_mask);
        addr_b  = addr_a | (CNT_W'(1) << r_lh);
        tw_k    = BF_W'((r_m & bf_mask) << (STAGE_W'(BF_W) - r_lh));
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_inv <= i_cfg_wr_data;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_bank     = r_bank;
        n_ready    = r_ready;
        n_xf_inv   = r_xf_inv;
        n_out_inv  = r_out_inv;
        n_xf_bank  = r_xf_bank;
        n_lh       = r_lh;
        n_m        = r_m;

        o_cmd           = '0;
        o_cmd.out_index = r_load_cnt;
        o_cmd.out_inv   = r_out_inv;
        o_cmd.neg_im    = r_xf_inv && (r_lh == '0);
        o_cmd.tw_upper  = (tw_k > BF_W'(QUARTER));
        o_cmd.tw_idx    = o_cmd.tw_upper ? (tw_k - BF_W'(QUARTER)) : tw_k;

        case (r_state)
            S_LOAD: begin
                o_cmd.rd_addr_a = {~r_bank, r_load_cnt};
                o_cmd.wr_addr   = {r_bank, bit_rev(r_load_cnt)};
                if (accept) begin
                    o_cmd.load_we = 1'b1;
                    o_cmd.out_rd  = r_ready;
                    n_load_cnt    = r_load_cnt + CNT_W'(1);
                    if (r_load_cnt == CNT_W'(POINTS - 1)) begin
                        n_bank    = ~r_bank;
                        n_ready   = 1'b1;
                        n_xf_bank = r_bank;
                        n_xf_inv  = r_inv;
                        n_lh      = '0;
                        n_m       = '0;
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.xf_rd     = 1'b1;
                o_cmd.rd_addr_a = {r_xf_bank, addr_a};
                o_cmd.rd_addr_b = {r_xf_bank, addr_b};
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_en = 1'b1;
                n_state      = S_WB;
            end
            S_WB: begin
                o_cmd.wr_b    = 1'b1;
                o_cmd.wr_addr = {r_xf_bank, addr_b};
                n_state       = S_WA;
            end
            S_WA: begin
                o_cmd.wr_a    = 1'b1;
                o_cmd.wr_addr = {r_xf_bank, addr_a};
                n_m           = r_m + BF_W'(1);
                n_state       = S_RD;
                if (r_m == BF_W'(HALF_PTS - 1)) begin
                    if (r_lh == STAGE_W'(LOG2_POINTS - 1)) begin
                        n_out_inv = r_xf_inv;
                        n_state   = S_LOAD;
                    end else begin
                        n_lh = r_lh + STAGE_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_bank     <= 1'b0;
            r_ready    <= 1'b0;
            r_xf_inv   <= 1'b0;
            r_out_inv  <= 1'b0;
            r_xf_bank  <= 1'b0;
            r_lh       <= '0;
            r_m        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_bank     <= n_bank;
            r_ready    <= n_ready;
            r_xf_inv   <= n_xf_inv;
            r_out_inv  <= n_out_inv;
            r_xf_bank  <= n_xf_bank;
            r_lh       <= n_lh;
            r_m        <= n_m;
        end
    end

endmodule

### design/r2fft_dpath.sv
// Datapath: frame store, twiddle ROM, butterfly arithmetic and output stage.
`timescale 1ns / 1ps
module r2fft_dpath
    import r2fft_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample_re,
    input  logic signed [SAMPLE_W-1:0] i_sample_im,
    output logic                       o_bin_valid,
    output logic signed [DATA_W-1:0]   o_bin_re,
    output logic signed [DATA_W-1:0]   o_bin_im,
    output logic [CNT_W-1:0]           o_bin_index,
    output logic                       o_last_bin
);

    localparam int WORD_W = 2 * DATA_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [WORD_W-1:0] r_mem [0:DEPTH-1];
    logic [WORD_W-1:0] r_rd_a;
    logic [WORD_W-1:0] r_rd_b;
    logic [WORD_W-1:0] wr_data;

    logic [TW_W-1:0]   r_tw_cos;
    logic [TW_W-1:0]   r_tw_sin;
    logic              r_tw_upper;

    logic signed [PROD_W-1:0] r_p_cbr, r_p_sbi, r_p_cbi, r_p_sbr;
    logic signed [DATA_W-1:0] r_ar, r_ai;
    logic signed [TR_W-1:0]   r_tr, r_ti;
    logic signed [DATA_W-1:0] r_ar2, r_ai2;
    logic [DATA_W-1:0]        r_res_a_re, r_res_a_im, r_res_b_re, r_res_b_im;

    logic                     r_out_pend;
    logic [CNT_W-1:0]         r_out_idx;
    logic                     r_out_inv;
    logic                     r_bin_valid;

    logic signed [TW_W-1:0]   tw_c, tw_s;
    logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im;
    logic signed [PROD_W:0]   sum_r, sum_i;
    logic signed [DATA_W:0]   sc_re, sc_im;

    // Frame store write data
    always_comb begin
        wr_data = {DATA_W'(i_sample_re), DATA_W'(i_sample_im)};
        if (i_cmd.wr_b) wr_data = {r_res_b_re, r_res_b_im};
        if (i_cmd.wr_a) wr_data = {r_res_a_re, r_res_a_im};
    end

    // Frame store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we || i_cmd.wr_a || i_cmd.wr_b) begin
            r_mem[i_cmd.wr_addr] <= wr_data;
        end
        if (i_cmd.out_rd || i_cmd.xf_rd) begin
            r_rd_a <= r_mem[i_cmd.rd_addr_a];
        end
        if (i_cmd.xf_rd) begin
            r_rd_b <= r_mem[i_cmd.rd_addr_b];
        end
    end

    // Twiddle ROM, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.xf_rd) begin
            r_tw_cos   <= COS_ROM[i_cmd.tw_idx];
            r_tw_sin   <= SIN_ROM[i_cmd.tw_idx];
            r_tw_upper <= i_cmd.tw_upper;
        end
    end

    // Operand select: second quarter rotates the table, first stage may conjugate
    always_comb begin
        tw_c = r_tw_upper ? -$signed(r_tw_sin) : $signed(r_tw_cos);
        tw_s = r_tw_upper ? $signed(r_tw_cos)  : $signed(r_tw_sin);
        a_re = $signed(r_rd_a[WORD_W-1:DATA_W]);
        a_im = $signed(r_rd_a[DATA_W-1:0]);
        b_re = $signed(r_rd_b[WORD_W-1:DATA_W]);
        b_im = $signed(r_rd_b[DATA_W-1:0]);
        if (i_cmd.neg_im) begin
            a_im = -a_im;
            b_im = -b_im;
        end
    end

    // Butterfly: products, rounded twiddle product, sum and difference
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p_cbr <= PROD_W'(tw_c * b_re);
            r_p_sbi <= PROD_W'(tw_s * b_im);
            r_p_cbi <= PROD_W'(tw_c * b_im);
            r_p_sbr <= PROD_W'(tw_s * b_re);
            r_ar    <= a_re;
            r_ai    <= a_im;
        end
        if (i_cmd.sum_en) begin
            r_tr  <= TR_W'(sum_r >>> (TW_W - 1));
            r_ti  <= TR_W'(sum_i >>> (TW_W - 1));
            r_ar2 <= r_ar;
            r_ai2 <= r_ai;
        end
        if (i_cmd.add_en) begin
            r_res_a_re <= sat_data(SUM_W'(r_ar2) + SUM_W'(r_tr));
            r_res_a_im <= sat_data(SUM_W'(r_ai2) + SUM_W'(r_ti));
            r_res_b_re <= sat_data(SUM_W'(r_ar2) - SUM_W'(r_tr));
            r_res_b_im <= sat_data(SUM_W'(r_ai2) - SUM_W'(r_ti));
        end
    end

    always_comb begin
        sum_r = (PROD_W+1)'(r_p_cbr) + (PROD_W+1)'(r_p_sbi)
              + (PROD_W+1)'(1 << (TW_W - 2));
        sum_i = (PROD_W+1)'(r_p_cbi) - (PROD_W+1)'(r_p_sbr)
              + (PROD_W+1)'(1 << (TW_W - 2));
    end

    // Inverse scaling with rounding and output conjugation
    always_comb begin
        sc_re = ((DATA_W+1)'($signed(r_rd_a[WORD_W-1:DATA_W])) + (DATA_W+1)'(HALF_PTS))
                >>> LOG2_POINTS;
        sc_im = ((DATA_W+1)'($signed(r_rd_a[DATA_W-1:0])) + (DATA_W+1)'(HALF_PTS))
                >>> LOG2_POINTS;
    end

    // Output stage: the bin is read into a register and strobed in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_pend  <= 1'b0;
            r_bin_valid <= 1'b0;
        end else begin
            r_out_pend  <= i_cmd.out_rd;
            r_bin_valid <= r_out_pend;
        end
        if (i_cmd.out_rd) begin
            r_out_idx <= i_cmd.out_index;
            r_out_inv <= i_cmd.out_inv;
        end
        if (r_out_pend) begin
            o_bin_index <= r_out_idx;
            o_last_bin  <= (r_out_idx == CNT_W'(POINTS - 1));
            if (r_out_inv) begin
                o_bin_re <= DATA_W'(sc_re);
                o_bin_im <= DATA_W'(-sc_im);
            end else begin
                o_bin_re <= $signed(r_rd_a[WORD_W-1:DATA_W]);
                o_bin_im <= $signed(r_rd_a[DATA_W-1:0]);
            end
        end
    end

    assign o_bin_valid = r_bin_valid;

endmodule

### design/radix2_fft_2048_top.sv
// Streaming 2048-point radix-2 DIT FFT: start reads a bin into a register, then strobes it.
// An accepted sample stores one value and reads out one bin of the previous frame.
// The 2048th sample starts an in-place transform of 11 x 1024 butterflies, each
// through read, multiply, sum, add, write-b and write-a steps on one shared
// butterfly unit and the one frame store write port; no sample is taken while busy.
// Reset is synchronous, active low; the receiver cannot stall the bin strobe.
`timescale 1ns / 1ps
module radix2_fft_2048_top
    import r2fft_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] i_sample_re,
    input  logic signed [SAMPLE_W-1:0] i_sample_im,
    output logic                       o_bin_valid,
    output logic signed [DATA_W-1:0]   o_bin_re,
    output logic signed [DATA_W-1:0]   o_bin_im,
    output logic [CNT_W-1:0]           o_bin_index,
    output logic                       o_last_bin
);

    t_cmd cmd;

    // Sequencer
    r2fft_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd         (cmd)
    );

    // Storage and arithmetic
    r2fft_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_bin_valid (o_bin_valid),
        .o_bin_re    (o_bin_re),
        .o_bin_im    (o_bin_im),
        .o_bin_index (o_bin_index),
        .o_last_bin  (o_last_bin)
    );

endmodule
